>>> src/radar_track_frame_decoder_macros.svh
// assertion macros for the radar track frame decoder checker
// no dependencies; included by the checker file only
`ifndef RADAR_TRACK_FRAME_DECODER_MACROS_SVH
`define RADAR_TRACK_FRAME_DECODER_MACROS_SVH

// same-cycle implication, reset masks the check
`define RTFD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define RTFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rtfd_pkg.sv
// shared types, constants and the sine table function of the track frame decoder
// no dependencies; imported by the decoder and its port checker
package rtfd_pkg;

  // field widths
  localparam int FRAME_ID_W   = 11;
  localparam int BYTE_W       = 8;
  localparam int TRACK_NUM_W  = 7;
  localparam int STATE_W      = 3;
  localparam int RANGE_W      = 11;
  localparam int POS_W        = 20;
  localparam int VEL_W        = 22;
  localparam int WIDTH_W      = 4;
  localparam int BATCH_W      = 7;
  localparam int ANGLE_RAW_W  = 13;
  localparam int ANGLE_FULL_W = 16;
  localparam int RATE_RAW_W   = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_FRAME_ID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_SIZE    = 2'd2;

  localparam logic [FRAME_ID_W-1:0] RST_BASE_FRAME_ID = 11'h500;
  localparam logic [FRAME_ID_W-1:0] RST_LAST_FRAME_ID = 11'h53F;
  localparam logic [BATCH_W-1:0]    RST_BATCH_SIZE    = 7'd32;

  localparam logic [BATCH_W-1:0] MAX_TRACKS = 7'd64;

  // parameter defaults
  localparam int DEF_ANGLE_BITS     = 10;
  localparam int DEF_RATE_BITS      = 14;
  localparam int DEF_TRIG_FRAC_BITS = 15;

  // angles in tenths of a degree
  localparam int ANGLE_MOD    = 3600;
  localparam int QUARTER_TURN = 900;
  localparam int TURN_W       = 12;
  localparam int QTR_W        = 10;

  localparam logic [63:0] PI_Q48  = 64'h0003_243F_6A88_85A3;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  // per-track fields that ride along the pipeline unchanged
  typedef struct packed {
    logic [TRACK_NUM_W-1:0] track_number;
    logic [STATE_W-1:0]     track_state;
    logic [WIDTH_W-1:0]     width_half_metres;
    logic                   rolling_bit;
    logic                   batch_first;
    logic                   batch_last;
  } track_info_t;

  // sine of u tenths of a degree (0..900), Horner Taylor series in Q30,
  // rounded to frac bits and clamped to one; evaluated only at elaboration
  function automatic logic [63:0] sin_tenth(input int unsigned u, input int unsigned frac);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] s;
    logic [63:0] v;
    x  = ((64'(u) * PI_Q48) / 64'd1800 + (64'd1 << 17)) >> 18;
    x2 = (x * x) >> 30;
    s  = Q30_ONE;
    s  = Q30_ONE - ((x2 * s) >> 30) / 64'd272;
    s  = Q30_ONE - ((x2 * s) >> 30) / 64'd210;
    s  = Q30_ONE - ((x2 * s) >> 30) / 64'd156;
    s  = Q30_ONE - ((x2 * s) >> 30) / 64'd110;
    s  = Q30_ONE - ((x2 * s) >> 30) / 64'd72;
    s  = Q30_ONE - ((x2 * s) >> 30) / 64'd42;
    s  = Q30_ONE - ((x2 * s) >> 30) / 64'd20;
    s  = Q30_ONE - ((x2 * s) >> 30) / 64'd6;
    v  = (x * s) >> 30;
    v  = (v + (64'd1 << (29 - frac))) >> (30 - frac);
    if (v > (64'd1 << frac)) begin
      v = 64'd1 << frac;
    end
    return v;
  endfunction

endpackage

>>> src/radar_track_frame_decoder.sv
// radar track frame decoder: batch tracking, field unpack, polar to cartesian
// depends on rtfd_pkg (widths, codes, sine table function)
//
// usage
//   frame channel (frame_valid / frame_stall): one CAN frame per transaction,
//   identifier plus data bytes 1,2,3,4,6,7. track channel (track_valid /
//   track_stall): one decoded track per counted frame; frames that are not
//   counted into a batch are taken and give no track transaction.
//   configuration is a plain write port (cfg_write_enable, cfg_index,
//   cfg_data), written while no frames are in flight.
//   pipeline: a counted frame reaches the track channel through the seven
//   register stages (angle offset, reciprocal multiply, remainder fix,
//   quadrant split, sine rom read, trig multiply, round and saturate), which
//   each hold one frame, so one frame per cycle goes through as long as the
//   receiver takes tracks.
//   stall: a stalled track holds in the output register; earlier stages keep
//   filling empty slots, and frame_stall rises once every stage is full.
//   reset: configuration returns to base 0x500, last 0x53F, batch size 32,
//   no batch is open and the pipeline is emptied.
//   the sine rom is a 901-entry constant table read at two addresses.
module radar_track_frame_decoder
  import rtfd_pkg::*;
#(
  parameter int ANGLE_BITS     = DEF_ANGLE_BITS,
  parameter int RATE_BITS      = DEF_RATE_BITS,
  parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration writes
  input  logic                   cfg_write_enable,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // frame channel
  input  logic                   frame_valid,
  output logic                   frame_stall,
  input  logic [FRAME_ID_W-1:0]  frame_id,
  input  logic [BYTE_W-1:0]      byte_one,
  input  logic [BYTE_W-1:0]      byte_two,
  input  logic [BYTE_W-1:0]      byte_three,
  input  logic [BYTE_W-1:0]      byte_four,
  input  logic [BYTE_W-1:0]      byte_six,
  input  logic [BYTE_W-1:0]      byte_seven,
  // track channel
  output logic                   track_valid,
  input  logic                   track_stall,
  output logic [TRACK_NUM_W-1:0] track_number,
  output logic [STATE_W-1:0]     track_state,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic signed [VEL_W-1:0] vel_x,
  output logic signed [VEL_W-1:0] vel_y,
  output logic [WIDTH_W-1:0]     width_half_metres,
  output logic                   rolling_bit,
  output logic                   batch_first,
  output logic                   batch_last
);

  localparam int STAGES = 7;
  localparam int TW     = TRIG_FRAC_BITS + 1;
  // multiple of a full turn that lifts every angle above zero
  localparam int ANG_OFS = ANGLE_MOD * ((2 ** (ANGLE_BITS - 1) + ANGLE_MOD - 1) / ANGLE_MOD);
  localparam int VW      = $clog2(ANG_OFS + 2 ** (ANGLE_BITS - 1));
  // reciprocal of a turn: quotient estimate is exact or one low
  localparam int RK      = VW + 12;
  localparam int RW      = VW + 1;
  localparam int QW      = VW - 11;
  localparam logic [RW-1:0] RECIP = RW'((64'd1 << RK) / 64'(ANGLE_MOD));
  localparam int VAL_W   = (RATE_BITS > RANGE_W) ? RATE_BITS : RANGE_W;
  localparam int PW      = VAL_W + TW;
  localparam int RNDW    = PW + 9;

  // configuration and batch state
  logic [FRAME_ID_W-1:0] base_frame_id;
  logic [FRAME_ID_W-1:0] last_frame_id;
  logic [BATCH_W-1:0]    batch_size;
  logic                  batch_started;
  logic [BATCH_W-1:0]    track_count;

  // pipeline handshake
  logic [STAGES:1]   stage_valid;
  logic [STAGES+1:1] stage_ready;

  // frame decode at the input
  logic [BATCH_W-1:0]      size_eff;
  logic                    is_base;
  logic                    take;
  logic                    frame_accept;
  logic [BATCH_W-1:0]      count_next;
  logic [FRAME_ID_W-1:0]   id_delta;
  logic [ANGLE_FULL_W-1:0] ang_full;
  logic [ANGLE_BITS-1:0]   ang_bits;
  logic [VW-1:0]           ang_lift;
  logic [RATE_RAW_W-1:0]   rate_full;
  logic [RATE_BITS-1:0]    rate_bits;
  track_info_t             info_in;

  // carried payload
  track_info_t          info_q     [1:STAGES];
  logic [RANGE_W-1:0]   range_q    [1:5];
  logic                 rate_neg_q [1:5];
  logic [RATE_BITS-1:0] rate_mag_q [1:5];

  // angle reduction
  logic [VW-1:0]     ang_v1;
  logic [VW-1:0]     ang_v2;
  logic [QW-1:0]     quot2;
  logic [VW+RW-1:0]  quot_prod;
  logic [VW-1:0]     turn_sub;
  logic [VW-1:0]     rem_est;
  logic [TURN_W-1:0] turn3;
  quad_t             quad_next;
  logic [QTR_W-1:0]  ofs_next;
  quad_t             quad4;
  logic [QTR_W-1:0]  ofs4;
  logic [QTR_W-1:0]  cofs4;

  // sine rom and its registered reads
  logic [TW-1:0] sin_rom [0:QUARTER_TURN];
  logic [TW-1:0] rom_t5;
  logic [TW-1:0] rom_c5;
  quad_t         quad5;

  // trig select and products
  logic [TW-1:0] sin_mag;
  logic [TW-1:0] cos_mag;
  logic          sin_neg;
  logic          cos_neg;
  logic [PW-1:0] prod_px;
  logic [PW-1:0] prod_py;
  logic [PW-1:0] prod_vx;
  logic [PW-1:0] prod_vy;
  logic          minus_px;
  logic          minus_py;
  logic          minus_vx;
  logic          minus_vy;

  // round to nearest on the magnitude, ties away from zero, then saturate
  function automatic logic [VEL_W-1:0] round_sat(input logic [PW-1:0] prod, input logic minus,
                                                 input int unsigned w);
    logic [RNDW-1:0] wide;
    logic [RNDW-1:0] mag;
    logic [RNDW-1:0] lim;
    logic [RNDW-1:0] res;
    wide = {1'b0, prod, 8'd0} + (RNDW'(1) << (TRIG_FRAC_BITS - 1));
    mag  = wide >> TRIG_FRAC_BITS;
    lim  = RNDW'(1) << (w - 1);
    if (!minus) begin
      res = (mag >= lim) ? (lim - RNDW'(1)) : mag;
    end else begin
      res = (mag > lim) ? (~lim + RNDW'(1)) : (~mag + RNDW'(1));
    end
    return res[VEL_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // handshake: a stage takes new data when empty or when the next one moves
  // ---------------------------------------------------------------------
  assign stage_ready[STAGES+1] = !track_stall;
  for (genvar g = 1; g <= STAGES; g++) begin : g_ready
    assign stage_ready[g] = !stage_valid[g] || stage_ready[g+1];
  end

  assign frame_stall  = !stage_ready[1];
  assign frame_accept = frame_valid && stage_ready[1];
  assign track_valid  = stage_valid[STAGES];

  // ---------------------------------------------------------------------
  // batch bookkeeping, decided when the frame transaction completes
  // ---------------------------------------------------------------------
  always_comb begin
    priority if (batch_size == '0) begin
      size_eff = BATCH_W'(1);
    end else if (batch_size > MAX_TRACKS) begin
      size_eff = MAX_TRACKS;
    end else begin
      size_eff = batch_size;
    end
  end

  assign is_base = (frame_id == base_frame_id);
  // a non-base frame counts only inside an open, unfilled batch
  assign take = is_base ||
                (batch_started && (frame_id > base_frame_id) &&
                 (frame_id <= last_frame_id) && (track_count < size_eff));
  assign count_next = is_base ? BATCH_W'(1) : (track_count + BATCH_W'(1));
  assign id_delta   = frame_id - base_frame_id;

  always_comb begin
    info_in.track_number      = id_delta[TRACK_NUM_W-1:0] + TRACK_NUM_W'(1);
    info_in.track_state       = byte_one[7:5];
    info_in.width_half_metres = byte_four[5:2];
    info_in.rolling_bit       = byte_four[6];
    info_in.batch_first       = is_base;
    info_in.batch_last        = (count_next == size_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_frame_id <= RST_BASE_FRAME_ID;
      last_frame_id <= RST_LAST_FRAME_ID;
      batch_size    <= RST_BATCH_SIZE;
      batch_started <= 1'b0;
      track_count   <= '0;
    end else begin
      if (cfg_write_enable) begin
        unique case (cfg_index)
          CFG_BASE_FRAME_ID: base_frame_id <= cfg_data;
          CFG_LAST_FRAME_ID: last_frame_id <= cfg_data;
          CFG_BATCH_SIZE:    batch_size    <= cfg_data[BATCH_W-1:0];
          default: ;  // unused index, write dropped
        endcase
      end
      if (frame_accept && take) begin
        batch_started <= 1'b1;
        track_count   <= count_next;
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage valid bits; frames that are not counted leave a bubble
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_ready[1]) begin
        stage_valid[1] <= frame_valid && take;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (stage_ready[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: unpack range, rate and angle; lift angle above zero
  // ---------------------------------------------------------------------
  assign ang_full  = ANGLE_FULL_W'({byte_one, byte_two[7:3]});
  assign ang_bits  = ang_full[ANGLE_BITS-1:0];
  assign ang_lift  = VW'(ANG_OFS) + {{(VW - ANGLE_BITS){ang_bits[ANGLE_BITS-1]}}, ang_bits};
  assign rate_full = {byte_six, byte_seven};
  assign rate_bits = rate_full[RATE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (stage_ready[1]) begin
      info_q[1]     <= info_in;
      range_q[1]    <= {byte_two[2:0], byte_three};
      rate_neg_q[1] <= rate_bits[RATE_BITS-1];
      rate_mag_q[1] <= rate_bits[RATE_BITS-1] ? (~rate_bits + RATE_BITS'(1)) : rate_bits;
      ang_v1        <= ang_lift;
    end
    for (int k = 2; k <= STAGES; k++) begin
      if (stage_ready[k]) begin
        info_q[k] <= info_q[k-1];
      end
    end
    for (int k = 2; k <= 5; k++) begin
      if (stage_ready[k]) begin
        range_q[k]    <= range_q[k-1];
        rate_neg_q[k] <= rate_neg_q[k-1];
        rate_mag_q[k] <= rate_mag_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: turns estimate by reciprocal multiply
  // ---------------------------------------------------------------------
  assign quot_prod = (VW+RW)'(ang_v1) * (VW+RW)'(RECIP);

  always_ff @(posedge clk) begin
    if (stage_ready[2]) begin
      quot2  <= quot_prod[VW+RW-1:RK];
      ang_v2 <= ang_v1;
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: remainder, at most one turn too large
  // ---------------------------------------------------------------------
  assign turn_sub = VW'(quot2 * ANGLE_MOD);
  assign rem_est  = ang_v2 - turn_sub;

  always_ff @(posedge clk) begin
    if (stage_ready[3]) begin
      turn3 <= (rem_est >= VW'(ANGLE_MOD)) ? TURN_W'(rem_est - VW'(ANGLE_MOD))
                                          : TURN_W'(rem_est);
    end
  end

  // ---------------------------------------------------------------------
  // stage 4: quadrant and offset within it
  // ---------------------------------------------------------------------
  always_comb begin
    priority if (turn3 >= TURN_W'(3 * QUARTER_TURN)) begin
      quad_next = QUAD_IV;
      ofs_next  = QTR_W'(turn3 - TURN_W'(3 * QUARTER_TURN));
    end else if (turn3 >= TURN_W'(2 * QUARTER_TURN)) begin
      quad_next = QUAD_III;
      ofs_next  = QTR_W'(turn3 - TURN_W'(2 * QUARTER_TURN));
    end else if (turn3 >= TURN_W'(QUARTER_TURN)) begin
      quad_next = QUAD_II;
      ofs_next  = QTR_W'(turn3 - TURN_W'(QUARTER_TURN));
    end else begin
      quad_next = QUAD_I;
      ofs_next  = QTR_W'(turn3);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready[4]) begin
      quad4 <= quad_next;
      ofs4  <= ofs_next;
      cofs4 <= QTR_W'(QUARTER_TURN) - ofs_next;
    end
  end

  // ---------------------------------------------------------------------
  // stage 5: sine rom, read at the offset and at its complement
  // ---------------------------------------------------------------------
  for (genvar g = 0; g <= QUARTER_TURN; g++) begin : g_rom
    assign sin_rom[g] = TW'(sin_tenth(g, TRIG_FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (stage_ready[5]) begin
      rom_t5 <= sin_rom[ofs4];
      rom_c5 <= sin_rom[cofs4];
      quad5  <= quad4;
    end
  end

  // ---------------------------------------------------------------------
  // stage 6: sign and magnitude of sin/cos, four products
  // ---------------------------------------------------------------------
  always_comb begin
    unique case (quad5)
      QUAD_I: begin
        sin_mag = rom_t5;  cos_mag = rom_c5;
        sin_neg = 1'b0;    cos_neg = 1'b0;
      end
      QUAD_II: begin
        sin_mag = rom_c5;  cos_mag = rom_t5;
        sin_neg = 1'b0;    cos_neg = 1'b1;
      end
      QUAD_III: begin
        sin_mag = rom_t5;  cos_mag = rom_c5;
        sin_neg = 1'b1;    cos_neg = 1'b1;
      end
      QUAD_IV: begin
        sin_mag = rom_c5;  cos_mag = rom_t5;
        sin_neg = 1'b1;    cos_neg = 1'b0;
      end
      default: begin
        sin_mag = rom_t5;  cos_mag = rom_c5;
        sin_neg = 1'b0;    cos_neg = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stage_ready[6]) begin
      prod_px  <= PW'(range_q[5]) * PW'(cos_mag);
      prod_py  <= PW'(range_q[5]) * PW'(sin_mag);
      prod_vx  <= PW'(rate_mag_q[5]) * PW'(cos_mag);
      prod_vy  <= PW'(rate_mag_q[5]) * PW'(sin_mag);
      // y axis points the other way, hence the inverted sine sign
      minus_px <= cos_neg;
      minus_py <= !sin_neg;
      minus_vx <= rate_neg_q[5] ^ cos_neg;
      minus_vy <= !(rate_neg_q[5] ^ sin_neg);
    end
  end

  // ---------------------------------------------------------------------
  // stage 7: output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (stage_ready[7]) begin
      pos_x <= POS_W'(round_sat(prod_px, minus_px, POS_W));
      pos_y <= POS_W'(round_sat(prod_py, minus_py, POS_W));
      vel_x <= round_sat(prod_vx, minus_vx, VEL_W);
      vel_y <= round_sat(prod_vy, minus_vy, VEL_W);
    end
  end

  assign track_number      = info_q[STAGES].track_number;
  assign track_state       = info_q[STAGES].track_state;
  assign width_half_metres = info_q[STAGES].width_half_metres;
  assign rolling_bit       = info_q[STAGES].rolling_bit;
  assign batch_first       = info_q[STAGES].batch_first;
  assign batch_last        = info_q[STAGES].batch_last;

endmodule

>>> src/rtfd_port_chk.sv
// port-level checks for the radar track frame decoder, bound to the top level
// depends on rtfd_pkg and radar_track_frame_decoder_macros.svh
`include "radar_track_frame_decoder_macros.svh"

module rtfd_port_chk
  import rtfd_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    frame_stall,
  input logic                    track_valid,
  input logic                    track_stall,
  input logic [TRACK_NUM_W-1:0]  track_number,
  input logic signed [POS_W-1:0] pos_x,
  input logic signed [VEL_W-1:0] vel_y,
  input logic                    batch_first,
  input logic                    batch_last
);

  `RTFD_ASSERT_NEXT(a_track_valid_holds, clk, rst, track_valid && track_stall, track_valid, "track transaction dropped while stalled")
  `RTFD_ASSERT_NEXT(a_track_payload_holds, clk, rst, track_valid && track_stall, $stable(track_number) && $stable(pos_x) && $stable(vel_y) && $stable(batch_last), "stalled track payload changed")
  `RTFD_ASSERT_IMPLY(a_first_is_track_one, clk, rst, track_valid && batch_first, track_number == TRACK_NUM_W'(1), "batch start track not numbered one")
  `RTFD_ASSERT_IMPLY(a_empty_output_takes_frames, clk, rst, !track_valid, !frame_stall, "frames stalled with an empty output")
  `RTFD_ASSERT_IMPLY(a_quiet_after_reset, clk, rst, $past(rst), !track_valid, "track shown right after reset")

endmodule

bind radar_track_frame_decoder rtfd_port_chk u_rtfd_port_chk (.*);
